[sv/set_assoc_lru_cache_model_defines.svh]
// ============================================================================
// Assertion macros for the set-associative LRU cache model
// Shared wrappers that keep every concurrent assertion in one house form.
// ============================================================================
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SALRU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A property that must hold in the cycle after a condition.
`define SALRU_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

[sv/salru_pkg.sv]
// ============================================================================
// Set-associative LRU cache package
// Field widths, register indexes, outcome codes and shared types.
// ============================================================================
package salru_pkg;

    localparam int ADDR_W      = 64;
    localparam int OUTCOME_W   = 2;
    localparam int WAY_OUT_W   = 3;
    localparam int COUNT_W     = 32;
    localparam int CFG_SET_W   = 3;
    localparam int CFG_BLOCK_W = 6;
    localparam int CFG_WAYS_W  = 4;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int SHIFT_W     = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic hit;
        logic best_valid;
    } scan_flags_t;

endpackage

[sv/salru_if.sv]
// ============================================================================
// Set-associative LRU cache channels
// Valid/ready channels for access items and result items.
// ============================================================================
interface salru_access_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [salru_pkg::ADDR_W-1:0]   address;

    modport source (output valid, command, address, input ready);
    modport sink (input valid, command, address, output ready);
endinterface

interface salru_result_if;
    logic                               valid;
    logic                               ready;
    logic [salru_pkg::OUTCOME_W-1:0]    outcome;
    logic [salru_pkg::WAY_OUT_W-1:0]    way_used;
    logic [salru_pkg::COUNT_W-1:0]      hit_total;
    logic [salru_pkg::COUNT_W-1:0]      miss_total;
    logic [salru_pkg::COUNT_W-1:0]      eviction_total;
    logic                               last_of_item;

    modport source (output valid, outcome, way_used, hit_total, miss_total,
                    eviction_total, last_of_item, input ready);
    modport sink (input valid, outcome, way_used, hit_total, miss_total,
                  eviction_total, last_of_item, output ready);
endinterface

[sv/salru_tag_store.sv]
// ============================================================================
// Cache tag store
// One-write, one-read memory of valid bit, tag and stamp for every line.
// ============================================================================
module salru_tag_store #(
    parameter int DEPTH   = 512,
    parameter int IDX_W   = 9,
    parameter int STAMP_W = 32
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic                            wr_valid,
    input  logic [salru_pkg::ADDR_W-1:0]    wr_tag,
    input  logic [STAMP_W-1:0]              wr_stamp,
    input  logic                            rd_en,
    input  logic [IDX_W-1:0]                rd_idx,
    output logic                            rd_valid,
    output logic [salru_pkg::ADDR_W-1:0]    rd_tag,
    output logic [STAMP_W-1:0]              rd_stamp
);

    localparam int ENTRY_W = 1 + salru_pkg::ADDR_W + STAMP_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= {wr_valid, wr_tag, wr_stamp};
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_idx];
        end
    end

    assign rd_valid = rd_entry_reg[ENTRY_W-1];
    assign rd_tag   = rd_entry_reg[ENTRY_W-2 -: salru_pkg::ADDR_W];
    assign rd_stamp = rd_entry_reg[STAMP_W-1:0];

endmodule

[sv/salru_scan_unit.sv]
// ============================================================================
// Way scan unit
// Takes one way of a set per cycle while step_valid is high; finds the first tag hit and the oldest way.
// ============================================================================
module salru_scan_unit #(
    parameter int WAY_W   = 3,
    parameter int STAMP_W = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_valid,
    input  logic [WAY_W-1:0]                step_way,
    input  logic                            entry_valid,
    input  logic [salru_pkg::ADDR_W-1:0]    entry_tag,
    input  logic [STAMP_W-1:0]              entry_stamp,
    input  logic [salru_pkg::ADDR_W-1:0]    key_tag,
    output salru_pkg::scan_flags_t          flags,
    output logic [WAY_W-1:0]                hit_way,
    output logic [WAY_W-1:0]                best_way
);

    logic               tag_hit;
    logic               first_way;
    logic               hit_reg;
    logic               hit_next;
    logic               best_valid_reg;
    logic               best_valid_next;
    logic [WAY_W-1:0]   hit_way_reg;
    logic [WAY_W-1:0]   hit_way_next;
    logic [WAY_W-1:0]   best_way_reg;
    logic [WAY_W-1:0]   best_way_next;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic [STAMP_W-1:0] best_stamp_next;

    assign tag_hit   = entry_valid && (entry_tag == key_tag);
    assign first_way = (step_way == '0);

    always_comb
    begin
        hit_next        = hit_reg;
        hit_way_next    = hit_way_reg;
        best_valid_next = best_valid_reg;
        best_way_next   = best_way_reg;
        best_stamp_next = best_stamp_reg;
        if (step_valid)
        begin
            if (first_way)
            begin
                hit_next        = tag_hit;
                hit_way_next    = step_way;
                best_valid_next = entry_valid;
                best_way_next   = step_way;
                best_stamp_next = entry_stamp;
            end
            else
            begin
                if (!hit_reg && tag_hit)
                begin
                    hit_next     = 1'b1;
                    hit_way_next = step_way;
                end
                if (entry_stamp < best_stamp_reg)
                begin
                    best_valid_next = entry_valid;
                    best_way_next   = step_way;
                    best_stamp_next = entry_stamp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg        <= hit_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_way_reg    <= hit_way_next;
        best_way_reg   <= best_way_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign flags.hit        = hit_reg;
    assign flags.best_valid = best_valid_reg;
    assign hit_way          = hit_way_reg;
    assign best_way         = best_way_reg;

endmodule

[sv/set_assoc_lru_cache_model.sv]
// ============================================================================
// Set-associative cache tag store with LRU replacement
// Each access item carries one address; a single access gives one result item
// and a modify gives two, one per lookup of the same address. A lookup reads
// the ways of its set from the tag store one per cycle through a single read
// port. With n the number of ways in use (ways_in_use held to the range 1 to
// MAX_WAYS), a lookup steps through prepare, a scan of the n ways, drain and
// emit; a modify runs the scan, drain and emit a second time before the next
// accept. A lookup whose result item finds the output register still full
// waits in its last step until the register is free. After reset the block
// first clears the tag store one line per cycle, all 2^MAX_SET_BITS * MAX_WAYS
// lines, and accepts no item meanwhile. A finished result waits in an output
// register while the next item is taken.
// ============================================================================
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int STAMP_WIDTH  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [salru_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
    salru_access_if.sink                        access,
    salru_result_if.source                      result
);

    `include "set_assoc_lru_cache_model_defines.svh"

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int DEPTH    = NUM_SETS * MAX_WAYS;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W     = $clog2(MAX_WAYS + 1);

    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PREP  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    function automatic logic [salru_pkg::COUNT_W-1:0] sat_inc(
        input logic [salru_pkg::COUNT_W-1:0] v
    );
        return (v == salru_pkg::COUNT_MAX) ? v : v + 1'b1;
    endfunction

    logic [salru_pkg::CFG_SET_W-1:0]    cfg_set_reg;
    logic [salru_pkg::CFG_BLOCK_W-1:0]  cfg_block_reg;
    logic [salru_pkg::CFG_WAYS_W-1:0]   cfg_ways_reg;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [IDX_W-1:0]                   clr_idx_reg;
    logic [IDX_W-1:0]                   clr_idx_next;
    logic                               second_reg;
    logic                               second_next;
    logic [WAY_W-1:0]                   rd_way_reg;
    logic [WAY_W-1:0]                   rd_way_next;
    logic                               step_valid_reg;
    logic [WAY_W-1:0]                   step_way_reg;
    logic [STAMP_WIDTH-1:0]             stamp_reg;
    logic [STAMP_WIDTH-1:0]             stamp_next;
    logic [salru_pkg::COUNT_W-1:0]      hit_cnt_reg;
    logic [salru_pkg::COUNT_W-1:0]      hit_cnt_next;
    logic [salru_pkg::COUNT_W-1:0]      miss_cnt_reg;
    logic [salru_pkg::COUNT_W-1:0]      miss_cnt_next;
    logic [salru_pkg::COUNT_W-1:0]      evict_cnt_reg;
    logic [salru_pkg::COUNT_W-1:0]      evict_cnt_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    logic                               cmd_reg;
    logic [salru_pkg::ADDR_W-1:0]       addr_reg;
    logic [salru_pkg::ADDR_W-1:0]       tag_reg;
    logic [IDX_W-1:0]                   set_base_reg;
    logic [NW_W-1:0]                    nw_reg;
    logic [salru_pkg::OUTCOME_W-1:0]    out_outcome_reg;
    logic [salru_pkg::WAY_OUT_W-1:0]    out_way_reg;
    logic                               out_last_reg;

    logic [salru_pkg::CFG_SET_W-1:0]    sb_val;
    logic [salru_pkg::ADDR_W-1:0]       shifted_addr;
    logic [SET_W-1:0]                   set_mask;
    logic [SET_W-1:0]                   set_val;
    logic [salru_pkg::SHIFT_W-1:0]      shift_sum;
    logic [salru_pkg::ADDR_W-1:0]       tag_val;
    logic [NW_W-1:0]                    nw_val;
    logic [IDX_W-1:0]                   base_val;

    logic                               in_fire;
    logic                               slot_free;
    logic                               emit_fire;
    logic                               way_last;
    logic [WAY_W-1:0]                   way_sel;
    logic [salru_pkg::OUTCOME_W-1:0]    outcome_val;

    logic                               wr_en;
    logic [IDX_W-1:0]                   wr_idx;
    logic                               wr_valid;
    logic [salru_pkg::ADDR_W-1:0]       wr_tag;
    logic [STAMP_WIDTH-1:0]             wr_stamp;
    logic                               rd_en;
    logic [IDX_W-1:0]                   rd_idx;
    logic                               rd_valid;
    logic [salru_pkg::ADDR_W-1:0]       rd_tag;
    logic [STAMP_WIDTH-1:0]             rd_stamp;

    salru_pkg::scan_flags_t             scan_flags;
    logic [WAY_W-1:0]                   hit_way;
    logic [WAY_W-1:0]                   best_way;

    salru_tag_store #(
        .DEPTH   (DEPTH),
        .IDX_W   (IDX_W),
        .STAMP_W (STAMP_WIDTH)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_valid (wr_valid),
        .wr_tag   (wr_tag),
        .wr_stamp (wr_stamp),
        .rd_en    (rd_en),
        .rd_idx   (rd_idx),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp)
    );

    salru_scan_unit #(
        .WAY_W   (WAY_W),
        .STAMP_W (STAMP_WIDTH)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_valid  (step_valid_reg),
        .step_way    (step_way_reg),
        .entry_valid (rd_valid),
        .entry_tag   (rd_tag),
        .entry_stamp (rd_stamp),
        .key_tag     (tag_reg),
        .flags       (scan_flags),
        .hit_way     (hit_way),
        .best_way    (best_way)
    );

    // Address decode from the registered address and the current configuration.
    always_comb
    begin
        sb_val       = (32'(cfg_set_reg) > MAX_SET_BITS)
                       ? salru_pkg::CFG_SET_W'(MAX_SET_BITS) : cfg_set_reg;
        shifted_addr = addr_reg >> cfg_block_reg;
        set_mask     = SET_W'((32'd1 << sb_val) - 32'd1);
        set_val      = shifted_addr[SET_W-1:0] & set_mask;
        shift_sum    = salru_pkg::SHIFT_W'(sb_val) + salru_pkg::SHIFT_W'(cfg_block_reg);
        tag_val      = (32'(shift_sum) >= salru_pkg::ADDR_W) ? '0 : (addr_reg >> shift_sum);
        if (cfg_ways_reg == '0)
        begin
            nw_val = NW_W'(1);
        end
        else if (32'(cfg_ways_reg) > MAX_WAYS)
        begin
            nw_val = NW_W'(MAX_WAYS);
        end
        else
        begin
            nw_val = NW_W'(cfg_ways_reg);
        end
        base_val = IDX_W'(32'(set_val) * MAX_WAYS);
    end

    assign in_fire   = access.valid && access.ready;
    assign slot_free = !out_valid_reg || result.ready;
    assign emit_fire = (state_reg == ST_EMIT) && slot_free;
    assign way_last  = (rd_way_reg == WAY_W'(nw_reg - 1'b1));
    assign way_sel   = scan_flags.hit ? hit_way : best_way;

    always_comb
    begin
        if (scan_flags.hit)
        begin
            outcome_val = salru_pkg::OUTCOME_HIT;
        end
        else if (scan_flags.best_valid)
        begin
            outcome_val = salru_pkg::OUTCOME_EVICT;
        end
        else
        begin
            outcome_val = salru_pkg::OUTCOME_FILL;
        end
    end

    always_comb
    begin
        rd_en  = (state_reg == ST_SCAN);
        rd_idx = set_base_reg + IDX_W'(rd_way_reg);
        if (state_reg == ST_CLEAR)
        begin
            wr_en    = 1'b1;
            wr_idx   = clr_idx_reg;
            wr_valid = 1'b0;
            wr_tag   = '0;
            wr_stamp = '0;
        end
        else
        begin
            wr_en    = emit_fire;
            wr_idx   = set_base_reg + IDX_W'(way_sel);
            wr_valid = 1'b1;
            wr_tag   = tag_reg;
            wr_stamp = stamp_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        second_next    = second_reg;
        rd_way_next    = rd_way_reg;
        stamp_next     = stamp_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IDX_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    second_next = 1'b0;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                rd_way_next = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (way_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_way_next = rd_way_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (stamp_reg != STAMP_MAX)
                    begin
                        stamp_next = stamp_reg + 1'b1;
                    end
                    if (scan_flags.hit)
                    begin
                        hit_cnt_next = sat_inc(hit_cnt_reg);
                    end
                    else
                    begin
                        miss_cnt_next = sat_inc(miss_cnt_reg);
                        if (scan_flags.best_valid)
                        begin
                            evict_cnt_next = sat_inc(evict_cnt_reg);
                        end
                    end
                    if (cmd_reg && !second_reg)
                    begin
                        second_next = 1'b1;
                        rd_way_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_set_reg    <= '0;
            cfg_block_reg  <= '0;
            cfg_ways_reg   <= salru_pkg::CFG_WAYS_W'(1);
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            second_reg     <= 1'b0;
            rd_way_reg     <= '0;
            step_valid_reg <= 1'b0;
            stamp_reg      <= STAMP_WIDTH'(1);
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    salru_pkg::REG_SET_BITS:
                    begin
                        cfg_set_reg <= cfg_data[salru_pkg::CFG_SET_W-1:0];
                    end
                    salru_pkg::REG_BLOCK_BITS:
                    begin
                        cfg_block_reg <= cfg_data[salru_pkg::CFG_BLOCK_W-1:0];
                    end
                    salru_pkg::REG_WAYS:
                    begin
                        cfg_ways_reg <= cfg_data[salru_pkg::CFG_WAYS_W-1:0];
                    end
                    default:
                    begin
                        cfg_set_reg <= cfg_set_reg;
                    end
                endcase
            end
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            second_reg     <= second_next;
            rd_way_reg     <= rd_way_next;
            step_valid_reg <= (state_reg == ST_SCAN);
            stamp_reg      <= stamp_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            evict_cnt_reg  <= evict_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_way_reg <= rd_way_reg;
        if (in_fire)
        begin
            cmd_reg  <= access.command;
            addr_reg <= access.address;
        end
        if (state_reg == ST_PREP)
        begin
            tag_reg      <= tag_val;
            set_base_reg <= base_val;
            nw_reg       <= nw_val;
        end
        if (emit_fire)
        begin
            out_outcome_reg <= outcome_val;
            out_way_reg     <= salru_pkg::WAY_OUT_W'(way_sel);
            out_last_reg    <= !(cmd_reg && !second_reg);
        end
    end

    assign access.ready          = (state_reg == ST_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.outcome        = out_outcome_reg;
    assign result.way_used       = out_way_reg;
    assign result.hit_total      = hit_cnt_reg;
    assign result.miss_total     = miss_cnt_reg;
    assign result.eviction_total = evict_cnt_reg;
    assign result.last_of_item   = out_last_reg;

    `SALRU_ASSERT(a_stamp_nonzero, clk, rst_n, stamp_reg != '0, "Stamp counter reached zero.")
    `SALRU_ASSERT(a_scan_way_range, clk, rst_n, (state_reg == ST_SCAN) |-> (NW_W'(rd_way_reg) < nw_reg), "Scan way beyond ways in use.")
    `SALRU_ASSERT_NEXT(a_hit_count_step, clk, rst_n, emit_fire && scan_flags.hit && (hit_cnt_reg != salru_pkg::COUNT_MAX), hit_cnt_reg == $past(hit_cnt_reg) + 1'b1, "Hit did not advance the hit count.")
    `SALRU_ASSERT_NEXT(a_modify_second, clk, rst_n, emit_fire && cmd_reg && !second_reg, (state_reg == ST_SCAN) && second_reg, "Modify did not start its second lookup.")

endmodule
